@@ hw/rtl/blc_pkg.sv @@
// Package for the blind and light actuator controller.
// Holds the word types, configuration and state records, register indexes and the duty table.
// No dependencies.
package blc_pkg;

    localparam int LUX_BITS = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_DAY_START_HOUR = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DAY_END_HOUR   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LUX_THRESHOLD  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OPEN_ANGLE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLEW_STEP      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SNAP_WINDOW    = 3'd5;

    localparam logic [1:0] LEVEL_OFF  = 2'd0;
    localparam logic [1:0] LEVEL_FILL = 2'd2;
    localparam logic [1:0] LEVEL_NIGHT = 2'd3;

    typedef struct packed {
        logic                auto_mode;
        logic                power_on;
        logic                person_present;
        logic [LUX_BITS-1:0] light_lux;
        logic [4:0]          hour_of_day;
        logic                hour_valid;
        logic [7:0]          requested_angle;
        logic [1:0]          requested_level;
    } tick_t;

    typedef struct packed {
        logic [7:0] servo_angle;
        logic       angle_written;
        logic       servo_enabled;
        logic [7:0] led_duty;
        logic [7:0] target_angle;
        logic [1:0] target_level;
        logic       state_changed;
    } result_t;

    typedef struct packed {
        logic [4:0]          day_start_hour;
        logic [4:0]          day_end_hour;
        logic [LUX_BITS-1:0] lux_threshold;
        logic [7:0]          open_angle;
        logic [3:0]          slew_step;
        logic [3:0]          snap_window;
    } cfg_t;

    typedef struct packed {
        logic [7:0] current_angle;
        logic       angle_known;
        logic [7:0] last_sent_angle;
        logic       last_sent_valid;
        logic       servo_attached;
        logic [7:0] shared_angle;
        logic [1:0] shared_level;
    } state_t;

    function automatic logic [7:0] duty_of(input logic [1:0] level);
        logic [7:0] duty;
        unique case (level)
            2'd0:    duty = 8'd0;
            2'd1:    duty = 8'd85;
            2'd2:    duty = 8'd170;
            default: duty = 8'd255;
        endcase
        return duty;
    endfunction

endpackage

@@ hw/rtl/blc_tick_logic.sv @@
// Combinational tick logic: target selection, slew step and servo attach control.
// Depends on blc_pkg for the word, configuration and state types.
module blc_tick_logic
    import blc_pkg::*;
(
    input  tick_t   tick,
    input  cfg_t    cfg,
    input  state_t  state,
    output state_t  state_next,
    output result_t result
);

    logic       daytime;
    logic [7:0] tgt_angle;
    logic [1:0] tgt_level;
    logic       changed;
    logic [7:0] start_angle;
    logic       attached_pre;
    logic [7:0] gap;
    logic [7:0] move;
    logic [7:0] new_angle;
    logic       written;

    always_comb
    begin
        state_next = state;
        daytime = !tick.hour_valid ||
                  (tick.hour_of_day >= cfg.day_start_hour &&
                   tick.hour_of_day < cfg.day_end_hour);
        tgt_angle = tick.requested_angle;
        tgt_level = tick.requested_level;
        changed   = 1'b0;

        if (tick.auto_mode && tick.power_on)
        begin
            if (daytime)
            begin
                tgt_angle = cfg.open_angle;
                tgt_level = (tick.person_present && tick.light_lux < cfg.lux_threshold)
                            ? LEVEL_FILL : LEVEL_OFF;
            end
            else
            begin
                tgt_angle = 8'd0;
                tgt_level = tick.person_present ? LEVEL_NIGHT : LEVEL_OFF;
            end
            if (state.shared_angle != tgt_angle || state.shared_level != tgt_level)
            begin
                state_next.shared_angle = tgt_angle;
                state_next.shared_level = tgt_level;
                changed = 1'b1;
            end
        end
        if (!tick.power_on)
        begin
            tgt_angle = 8'd0;
            tgt_level = LEVEL_OFF;
            state_next.shared_angle = 8'd0;
            state_next.shared_level = LEVEL_OFF;
        end

        start_angle  = state.angle_known ? state.current_angle : tgt_angle;
        attached_pre = state.servo_attached || (start_angle != tgt_angle);
        gap = (start_angle > tgt_angle) ? (start_angle - tgt_angle)
                                        : (tgt_angle - start_angle);
        move = ({4'd0, cfg.slew_step} < gap) ? {4'd0, cfg.slew_step} : gap;

        if (gap > {4'd0, cfg.snap_window})
        begin
            new_angle = (start_angle < tgt_angle) ? (start_angle + move)
                                                  : (start_angle - move);
        end
        else
        begin
            new_angle = tgt_angle;
        end

        written = !state.last_sent_valid || (state.last_sent_angle != new_angle);

        state_next.current_angle   = new_angle;
        state_next.angle_known     = 1'b1;
        state_next.last_sent_angle = new_angle;
        state_next.last_sent_valid = 1'b1;
        state_next.servo_attached  = written ? attached_pre : 1'b0;

        result.servo_angle   = new_angle;
        result.angle_written = written;
        result.servo_enabled = state_next.servo_attached;
        result.led_duty      = duty_of(tgt_level);
        result.target_angle  = tgt_angle;
        result.target_level  = tgt_level;
        result.state_changed = changed;
    end

endmodule

@@ hw/rtl/blind_and_light_actuator_controller_unit.sv @@
// Top level of the blind and light actuator controller.
// Depends on blc_pkg and instantiates blc_tick_logic.
//
// Each tick word passes an input register and then a result register. A new tick can be taken
// in every cycle while the result side does not stall; the rate is set by the single update of
// the controller state as a word enters the result register. One tick can wait in the input
// register while a finished result is stalled. Configuration writes are always ready and take
// effect on the next tick that reaches the logic.
module blind_and_light_actuator_controller_unit
    import blc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   tick_valid,
    output logic                   tick_stall,
    input  tick_t                  tick,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic    in_valid_reg;
    tick_t   in_data_reg;
    logic    out_valid_reg;
    result_t out_data_reg;
    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;
    logic    out_free;
    logic    advance;

    assign out_free   = !out_valid_reg || !result_stall;
    assign advance    = in_valid_reg && out_free;
    assign tick_stall = in_valid_reg && !out_free;
    assign cfg_ready  = 1'b1;

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    blc_tick_logic u_tick_logic (
        .tick       (in_data_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!tick_stall)
            begin
                in_valid_reg <= tick_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_valid && !tick_stall)
        begin
            in_data_reg <= tick;
        end
        if (advance)
        begin
            out_data_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.current_angle   <= 8'd0;
            state_reg.angle_known     <= 1'b0;
            state_reg.last_sent_angle <= 8'd0;
            state_reg.last_sent_valid <= 1'b0;
            state_reg.servo_attached  <= 1'b1;
            state_reg.shared_angle    <= 8'd0;
            state_reg.shared_level    <= LEVEL_OFF;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.day_start_hour <= 5'd7;
            cfg_reg.day_end_hour   <= 5'd19;
            cfg_reg.lux_threshold  <= LUX_BITS'(200);
            cfg_reg.open_angle     <= 8'd90;
            cfg_reg.slew_step      <= 4'd3;
            cfg_reg.snap_window    <= 4'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DAY_START_HOUR: cfg_reg.day_start_hour <= cfg_data[4:0];
                CFG_DAY_END_HOUR:   cfg_reg.day_end_hour   <= cfg_data[4:0];
                CFG_LUX_THRESHOLD:  cfg_reg.lux_threshold  <= cfg_data[LUX_BITS-1:0];
                CFG_OPEN_ANGLE:     cfg_reg.open_angle     <= cfg_data[7:0];
                CFG_SLEW_STEP:      cfg_reg.slew_step      <= cfg_data[3:0];
                CFG_SNAP_WINDOW:    cfg_reg.snap_window    <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // A new angle is only ever sent while the servo drive is attached.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!result.angle_written || result.servo_enabled))
        else $error("angle written while servo detached");

    // Automatic mode never chooses the first light level.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.state_changed) |-> (result.target_level != 2'd1))
        else $error("state change with a level automatic mode cannot choose");

    // The input side only stalls when a word is held in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_stall |-> (in_valid_reg && out_valid_reg))
        else $error("tick stalled with no word held");

    // After any tick the last sent angle follows the current angle.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.angle_known |-> (state_reg.last_sent_angle == state_reg.current_angle))
        else $error("last sent angle differs from current angle");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the blind and light actuator controller unit.
// Depends on blc_pkg and the RTL of blind_and_light_actuator_controller_unit.
// A scoreboard class predicts each result word, and plain tasks drive ticks and register writes.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import blc_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 144;

    class actuator_scoreboard;
        cfg_t       regs;
        logic [7:0] servo_pos;
        logic       pos_known;
        logic [7:0] sent_angle;
        logic       sent_valid;
        logic       attached;
        logic [7:0] shared_angle;
        logic [1:0] shared_level;
        result_t    expected_words[$];
        int         failures;

        function new();
            regs.day_start_hour = 5'd7;
            regs.day_end_hour   = 5'd19;
            regs.lux_threshold  = 16'd200;
            regs.open_angle     = 8'd90;
            regs.slew_step      = 4'd3;
            regs.snap_window    = 4'd2;
            servo_pos    = '0;
            pos_known    = 1'b0;
            sent_angle   = '0;
            sent_valid   = 1'b0;
            attached     = 1'b1;
            shared_angle = '0;
            shared_level = LEVEL_OFF;
            failures     = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DAY_START_HOUR: regs.day_start_hour = data[4:0];
                CFG_DAY_END_HOUR:   regs.day_end_hour   = data[4:0];
                CFG_LUX_THRESHOLD:  regs.lux_threshold  = data[LUX_BITS-1:0];
                CFG_OPEN_ANGLE:     regs.open_angle     = data[7:0];
                CFG_SLEW_STEP:      regs.slew_step      = data[3:0];
                CFG_SNAP_WINDOW:    regs.snap_window    = data[3:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] duty_for(logic [1:0] lvl);
            logic [7:0] duty;
            case (lvl)
                LEVEL_OFF:   duty = 8'd0;
                LEVEL_FILL:  duty = 8'd170;
                LEVEL_NIGHT: duty = 8'd255;
                default:     duty = 8'd85;
            endcase
            return duty;
        endfunction

        function void note_tick(tick_t t);
            logic [7:0] aim;
            logic [1:0] lvl;
            logic       day;
            logic       changed;
            logic       written;
            logic [7:0] gap;
            logic [7:0] mv;
            result_t    r;
            aim = t.requested_angle;
            lvl = t.requested_level;
            changed = 1'b0;
            written = 1'b0;
            if (t.auto_mode && t.power_on) begin
                day = !t.hour_valid || (t.hour_of_day >= regs.day_start_hour
                                        && t.hour_of_day < regs.day_end_hour);
                if (day) begin
                    aim = regs.open_angle;
                    lvl = (t.person_present && t.light_lux < regs.lux_threshold)
                          ? LEVEL_FILL : LEVEL_OFF;
                end
                else begin
                    aim = 8'd0;
                    lvl = t.person_present ? LEVEL_NIGHT : LEVEL_OFF;
                end
                if (shared_angle != aim || shared_level != lvl) begin
                    shared_angle = aim;
                    shared_level = lvl;
                    changed = 1'b1;
                end
            end
            if (!t.power_on) begin
                aim = 8'd0;
                lvl = LEVEL_OFF;
                shared_angle = 8'd0;
                shared_level = LEVEL_OFF;
            end
            if (!pos_known) begin
                servo_pos = aim;
                pos_known = 1'b1;
            end
            if (servo_pos != aim)
                attached = 1'b1;
            gap = (servo_pos > aim) ? servo_pos - aim : aim - servo_pos;
            if (gap > 8'(regs.snap_window)) begin
                mv = (8'(regs.slew_step) < gap) ? 8'(regs.slew_step) : gap;
                if (servo_pos < aim)
                    servo_pos = servo_pos + mv;
                else
                    servo_pos = servo_pos - mv;
            end
            else begin
                servo_pos = aim;
            end
            if (!sent_valid || sent_angle != servo_pos) begin
                written = 1'b1;
                sent_angle = servo_pos;
                sent_valid = 1'b1;
            end
            else begin
                attached = 1'b0;
            end
            r.servo_angle   = servo_pos;
            r.angle_written = written;
            r.servo_enabled = attached;
            r.led_duty      = duty_for(lvl);
            r.target_angle  = aim;
            r.target_level  = lvl;
            r.state_changed = changed;
            expected_words.push_back(r);
        endfunction

        function void check_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                failures++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_words.size() == 0) begin
                $error("result word arrived with no expected word pending");
                failures++;
                return;
            end
            want = expected_words.pop_front();
            check_field("servo_angle", want.servo_angle, got.servo_angle);
            check_field("angle_written", 8'(want.angle_written), 8'(got.angle_written));
            check_field("servo_enabled", 8'(want.servo_enabled), 8'(got.servo_enabled));
            check_field("led_duty", want.led_duty, got.led_duty);
            check_field("target_angle", want.target_angle, got.target_angle);
            check_field("target_level", 8'(want.target_level), 8'(got.target_level));
            check_field("state_changed", 8'(want.state_changed), 8'(got.state_changed));
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   tick_valid;
    logic                   tick_stall;
    tick_t                  tick;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    actuator_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count = 0;

    blind_and_light_actuator_controller_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (result_valid && !result_stall)
                sb.check_result(result);
            if (cfg_valid && cfg_ready)
                sb.write_register(cfg_index, cfg_data);
            if (tick_valid && !tick_stall)
                sb.note_tick(tick);
        end
    end

    always @(negedge clk) begin
        result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    function automatic tick_t make_tick(logic a, logic p, logic person, logic [15:0] lux,
                                        logic [4:0] hour, logic hv, logic [7:0] ang,
                                        logic [1:0] lvl);
        tick_t t;
        t.auto_mode       = a;
        t.power_on        = p;
        t.person_present  = person;
        t.light_lux       = lux;
        t.hour_of_day     = hour;
        t.hour_valid      = hv;
        t.requested_angle = ang;
        t.requested_level = lvl;
        return t;
    endfunction

    function automatic tick_t next_tick(tick_t prev);
        tick_t t;
        if ($urandom_range(0, 99) < 35) begin
            t = prev;
            if ($urandom_range(0, 1) == 1)
                t.light_lux = 16'($urandom);
            return t;
        end
        t.auto_mode      = ($urandom_range(0, 99) < 70);
        t.power_on       = ($urandom_range(0, 99) < 85);
        t.person_present = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: t.light_lux = 16'($urandom);
            1: t.light_lux = sb.regs.lux_threshold + 16'($urandom_range(0, 4)) - 16'd2;
            2: t.light_lux = 16'($urandom_range(0, 255));
            default: t.light_lux = 16'($urandom_range(60000, 65535));
        endcase
        t.hour_of_day = ($urandom_range(0, 99) < 80) ? 5'($urandom_range(0, 23))
                                                      : 5'($urandom_range(0, 31));
        t.hour_valid      = ($urandom_range(0, 99) < 80);
        t.requested_angle = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 180))
                                                          : 8'($urandom_range(0, 255));
        t.requested_level = 2'($urandom_range(0, 3));
        return t;
    endfunction

    task automatic send_tick(tick_t t);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            tick_valid <= 1'b0;
            @(negedge clk);
        end
        tick_valid <= 1'b1;
        tick <= t;
        @(posedge clk);
        while (tick_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_settings(cfg_t c);
        write_reg(CFG_DAY_START_HOUR, CFG_DATA_W'(c.day_start_hour));
        write_reg(CFG_DAY_END_HOUR, CFG_DATA_W'(c.day_end_hour));
        write_reg(CFG_LUX_THRESHOLD, CFG_DATA_W'(c.lux_threshold));
        write_reg(CFG_OPEN_ANGLE, CFG_DATA_W'(c.open_angle));
        write_reg(CFG_SLEW_STEP, CFG_DATA_W'(c.slew_step));
        write_reg(CFG_SNAP_WINDOW, CFG_DATA_W'(c.snap_window));
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial begin
        tick_t directed[$];
        tick_t prev;
        cfg_t  setting;
        int    phase;

        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n <= 1'b0;
        tick_valid <= 1'b0;
        tick <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed.push_back(make_tick(1'b1, 1'b1, 1'b1, 16'd0, 5'd12, 1'b1, 8'd0, 2'd0));
        directed.push_back(make_tick(1'b1, 1'b1, 1'b1, 16'd199, 5'd12, 1'b1, 8'd0, 2'd0));
        directed.push_back(make_tick(1'b1, 1'b1, 1'b1, 16'd200, 5'd12, 1'b1, 8'd0, 2'd0));
        directed.push_back(make_tick(1'b1, 1'b1, 1'b1, 16'hFFFF, 5'd7, 1'b1, 8'd0, 2'd0));
        directed.push_back(make_tick(1'b1, 1'b1, 1'b1, 16'd0, 5'd19, 1'b1, 8'd0, 2'd0));
        directed.push_back(make_tick(1'b1, 1'b1, 1'b0, 16'd0, 5'd22, 1'b1, 8'd0, 2'd0));
        directed.push_back(make_tick(1'b1, 1'b1, 1'b1, 16'd0, 5'd31, 1'b1, 8'd0, 2'd0));
        directed.push_back(make_tick(1'b1, 1'b1, 1'b1, 16'd0, 5'd31, 1'b0, 8'd0, 2'd0));
        directed.push_back(make_tick(1'b0, 1'b1, 1'b0, 16'd0, 5'd0, 1'b0, 8'd180, 2'd1));
        directed.push_back(make_tick(1'b0, 1'b1, 1'b1, 16'hFFFF, 5'd23, 1'b1, 8'd255, 2'd3));
        directed.push_back(make_tick(1'b0, 1'b1, 1'b1, 16'hFFFF, 5'd23, 1'b1, 8'd255, 2'd3));
        directed.push_back(make_tick(1'b0, 1'b1, 1'b0, 16'd0, 5'd0, 1'b1, 8'd0, 2'd2));
        directed.push_back(make_tick(1'b1, 1'b0, 1'b1, 16'd0, 5'd12, 1'b1, 8'd180, 2'd3));
        directed.push_back(make_tick(1'b0, 1'b0, 1'b1, 16'd0, 5'd12, 1'b1, 8'd180, 2'd3));
        for (int i = 0; i < 4; i++)
            directed.push_back(make_tick(1'b0, 1'b0, 1'b1, 16'd0, 5'd12, 1'b1, 8'd180, 2'd3));
        directed.push_back(make_tick(1'b1, 1'b1, 1'b0, 16'd0, 5'd0, 1'b0, 8'd0, 2'd0));
        directed.push_back(make_tick(1'b1, 1'b1, 1'b1, 16'd5, 5'd18, 1'b1, 8'd77, 2'd1));
        foreach (directed[i])
            send_tick(directed[i]);
        prev = directed[directed.size() - 1];

        for (phase = 0; phase < 8; phase++) begin
            if (phase > 0) begin
                tick_valid <= 1'b0;
                wait_idle();
                case (phase)
                    1: setting = '{5'd0, 5'd24, 16'hFFFF, 8'd180, 4'd15, 4'd15};
                    2: setting = '{5'd23, 5'd0, 16'd0, 8'd0, 4'd1, 4'd0};
                    3: setting = '{5'd31, 5'd31, 16'd1, 8'd255, 4'd0, 4'd0};
                    default: begin
                        setting.day_start_hour = 5'($urandom_range(0, 23));
                        setting.day_end_hour   = 5'($urandom_range(0, 24));
                        setting.lux_threshold  = 16'($urandom);
                        setting.open_angle     = 8'($urandom_range(0, 180));
                        setting.slew_step      = 4'($urandom_range(1, 15));
                        setting.snap_window    = 4'($urandom_range(0, 15));
                    end
                endcase
                write_settings(setting);
            end
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            repeat (PHASE_ITEMS) begin
                prev = next_tick(prev);
                send_tick(prev);
            end
        end

        tick_valid <= 1'b0;
        wait_idle();
        repeat (10) @(posedge clk);
        if (sb.failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
